FILE: rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and step codes for the point-in-polygon parity unit.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Multiply steps of one edge test. Even steps load the accumulator,
  // odd steps subtract and store one determinant (X, then Y, then Z).
  localparam logic [2:0] STEP_DQX_EY = 3'd0;
  localparam logic [2:0] STEP_DQY_EX = 3'd1;
  localparam logic [2:0] STEP_FY_DQX = 3'd2;
  localparam logic [2:0] STEP_FX_DQY = 3'd3;
  localparam logic [2:0] STEP_FX_EY  = 3'd4;
  localparam logic [2:0] STEP_FY_EX  = 3'd5;

  typedef struct packed {
    logic       capture;  // take the input beat
    logic       setup;    // form the edge differences
    logic       close;    // edge runs from the last vertex back to the start
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       acc_en;
    logic [2:0] acc_sel;
    logic       eval;     // fold the hit test into the parity
    logic       emit;     // load the result beat
  } pip_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic out_busy;
  } pip_status_t;

endpackage

FILE: rtl/pip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer for the point-in-polygon unit: runs the edge tests of each
// vertex beat through the shared multiplier and hands out the result.
// ----------------------------------------------------------------------------
module pip_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 ready,
  output pip_pkg::pip_cmd_t    cmd,
  input  pip_pkg::pip_status_t status
);
  import pip_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUTE = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_EVAL  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] step, step_next;
  logic       close, close_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      close <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      close <= close_next;
    end
  end

  assign ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    step_next   = step;
    close_next  = close;
    cmd         = '0;
    cmd.close   = close;
    cmd.mul_sel = step;
    cmd.acc_sel = step - 3'd1;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = ST_ROUTE;
      end
      ST_ROUTE: begin
        if (!status.first) begin
          close_next = 1'b0;
          state_next = ST_SETUP;
        end else if (status.last) begin
          close_next = 1'b1;
          state_next = ST_SETUP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        step_next  = STEP_DQX_EY;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        // The product of the previous step is folded in while this one runs.
        cmd.acc_en = (step != STEP_DQX_EY);
        if (step == STEP_FY_EX) begin
          state_next = ST_DRAIN;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_DRAIN: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = STEP_FY_EX;
        state_next  = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (!close && status.last) begin
          close_next = 1'b1;
          state_next = ST_SETUP;
        end else if (status.last) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_busy)
    else $error("result beat loaded over a pending one");

  a_setup_starts_mul: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETUP |=> state == ST_MUL && step == STEP_DQX_EY)
    else $error("edge test did not start at the first step");

  a_eval_after_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> $past(state) == ST_DRAIN)
    else $error("hit test evaluated before all determinants were stored");

  a_capture_route: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == ST_ROUTE)
    else $error("accepted beat not routed");
`endif

endmodule

FILE: rtl/pip_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_dp
// Datapath for the point-in-polygon unit: vertex registers, edge differences,
// one shared multiplier, determinant accumulator, parity and result register.
// ----------------------------------------------------------------------------
module pip_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pip_pkg::pip_cmd_t             cmd,
  output pip_pkg::pip_status_t          status,
  input  logic signed [COORD_WIDTH-1:0] query_x,
  input  logic signed [COORD_WIDTH-1:0] query_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic                          first_vertex,
  input  logic                          last_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          inside_res
);
  import pip_pkg::*;

  // Differences must hold the far point minus any coordinate.
  localparam int FAR_W = FRAC_BITS + 10;
  localparam int DW    = ((COORD_WIDTH > FAR_W) ? COORD_WIDTH : FAR_W) + 2;
  localparam int PW    = 2 * DW;
  localparam int RW    = PW + 1;
  localparam logic signed [DW-1:0] FAR_PT = -(DW'(1000) << FRAC_BITS);

  logic signed [COORD_WIDTH-1:0] qx, qy, vx, vy;
  logic signed [COORD_WIDTH-1:0] start_x, start_y, prior_x, prior_y;
  logic first_r, last_r;
  logic crossing_parity;

  logic signed [DW-1:0] dqx, dqy, ex, ey, fx, fy;
  logic signed [DW-1:0] cx_e, cy_e, dx_e, dy_e, qx_e, qy_e;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod, acc;
  logic signed [RW-1:0] det_x, det_y, det_z, det_new;
  logic hit;

  // Input capture and polygon state.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x         <= '0;
      start_y         <= '0;
      prior_x         <= '0;
      prior_y         <= '0;
      crossing_parity <= 1'b0;
      first_r         <= 1'b0;
      last_r          <= 1'b0;
    end else begin
      if (cmd.capture) begin
        first_r <= first_vertex;
        last_r  <= last_vertex;
        if (first_vertex) begin
          start_x         <= vertex_x;
          start_y         <= vertex_y;
          prior_x         <= vertex_x;
          prior_y         <= vertex_y;
          crossing_parity <= 1'b0;
        end
      end
      // The open edge reads the old prior vertex in this cycle.
      if (cmd.setup && !cmd.close) begin
        prior_x <= vx;
        prior_y <= vy;
      end
      if (cmd.eval && hit) crossing_parity <= !crossing_parity;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qx <= query_x;
      qy <= query_y;
      vx <= vertex_x;
      vy <= vertex_y;
    end
  end

  assign status.first = first_r;
  assign status.last  = last_r;

  // Edge C->D: the open edge runs prior->vertex, the closing edge vertex->start.
  assign cx_e = cmd.close ? DW'(vx) : DW'(prior_x);
  assign cy_e = cmd.close ? DW'(vy) : DW'(prior_y);
  assign dx_e = cmd.close ? DW'(start_x) : DW'(vx);
  assign dy_e = cmd.close ? DW'(start_y) : DW'(vy);
  assign qx_e = DW'(qx);
  assign qy_e = DW'(qy);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      dqx <= cx_e - qx_e;
      dqy <= cy_e - qy_e;
      ex  <= dx_e - cx_e;
      ey  <= dy_e - cy_e;
      fx  <= FAR_PT - qx_e;
      fy  <= FAR_PT - qy_e;
    end
  end

  // X = dq x e, Y = dq x f (equal to f x (Q - C)), Z = f x e.
  always_comb begin
    case (cmd.mul_sel)
      STEP_DQX_EY: begin mul_a = dqx; mul_b = ey; end
      STEP_DQY_EX: begin mul_a = dqy; mul_b = ex; end
      STEP_FY_DQX: begin mul_a = fy;  mul_b = dqx; end
      STEP_FX_DQY: begin mul_a = fx;  mul_b = dqy; end
      STEP_FX_EY:  begin mul_a = fx;  mul_b = ey; end
      STEP_FY_EX:  begin mul_a = fy;  mul_b = ex; end
      default:     begin mul_a = '0;  mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= PW'(mul_a) * PW'(mul_b);
  end

  assign det_new = RW'(acc) - RW'(prod);

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      case (cmd.acc_sel) inside
        STEP_DQX_EY, STEP_FY_DQX, STEP_FX_EY: acc <= prod;
        STEP_DQY_EX: det_x <= det_new;
        STEP_FX_DQY: det_y <= det_new;
        STEP_FY_EX:  det_z <= det_new;
        default: ;
      endcase
    end
  end

  // A hit needs Z nonzero and both X and Y in the closed range from 0 to Z.
  always_comb begin
    if (det_z == '0) begin
      hit = 1'b0;
    end else if (!det_z[RW-1]) begin
      hit = !det_x[RW-1] && (det_x <= det_z) && !det_y[RW-1] && (det_y <= det_z);
    end else begin
      hit = (det_x <= RW'(0)) && (det_x >= det_z) && (det_y <= RW'(0)) && (det_y >= det_z);
    end
  end

  // Result register: holds one beat while the next item is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) inside_res <= crossing_parity;
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

FILE: rtl/point_in_polygon_parity_unit.sv
`timescale 1ns / 1ps
// Edge tests per beat: one for a vertex that is neither first nor last, none for a first
// vertex, two for a last vertex (one if it is also the first).
// m_tvalid rises once the edge tests of a last vertex are done and no result waits.
// Each edge test runs on the single shared multiplier: setup, six products, drain
// and evaluate. One beat is worked on at a time.
// Reset (synchronous, rst high) clears the polygon state, parity and control.
// ----------------------------------------------------------------------------
// point_in_polygon_parity_unit
// Even-odd point-in-polygon test over a stream of polygon vertices.
// ----------------------------------------------------------------------------
module point_in_polygon_parity_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // query_x, query_y, vertex_x, vertex_y (lowest bits first)
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic [0:0]                          s_tuser,  // first_vertex
  input  logic                                s_tlast,  // last_vertex
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata   // inside_res
);
  import pip_pkg::*;

  pip_cmd_t    cmd;
  pip_status_t status;
  logic        inside_flag;

  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .ready    (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  pip_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .query_x      ($signed(s_tdata[COORD_WIDTH-1:0])),
    .query_y      ($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
    .vertex_x     ($signed(s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
    .vertex_y     ($signed(s_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH])),
    .first_vertex (s_tuser[0]),
    .last_vertex  (s_tlast),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .inside_res   (inside_flag)
  );

  assign m_tdata = {7'b0, inside_flag};

endmodule
